>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define FMFC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define FMFC_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define FMFC_ASSERT(label, clk, rst, prop, msg)
`define FMFC_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> rtl/fmfc_pkg.sv
// ----------------------------------------------------------------------------
// fmfc_pkg
// shared types and constants of the fix message framer and checker
// ----------------------------------------------------------------------------
package fmfc_pkg;

   // framing limits
   localparam int MAX_LENGTH_DIGITS = 10;
   localparam int VERSION_BYTES     = 7;
   localparam int BEGIN_TAG_LEN     = 2;
   localparam int LEN_TAG_LEN       = 2;
   localparam int SUM_TAG_LEN       = 3;
   localparam int SUM_DIGITS        = 3;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int STATUS_W  = 4;
   localparam int VERSION_W = 56;
   localparam int LENGTH_W  = 32;
   localparam int COUNT_W   = 33;
   localparam int SUM_W     = 8;
   localparam int TRAILER_W = 10;
   localparam int POS_W     = $clog2(VERSION_BYTES + 1);
   localparam int DIGIT_W   = $clog2(MAX_LENGTH_DIGITS + 1);

   localparam logic [LENGTH_W-1:0] MAX_BODY_RESET = 32'd1048576;

   // characters
   localparam logic [BYTE_W-1:0] CHAR_SOH = 8'h01;
   localparam logic [BYTE_W-1:0] CHAR_0   = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_1   = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_8   = 8'h38;
   localparam logic [BYTE_W-1:0] CHAR_9   = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_EQ  = 8'h3D;

   // request modes
   localparam logic MODE_DATA   = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK             = 4'd0;
   localparam logic [STATUS_W-1:0] ST_BEGIN_TAG      = 4'd1;
   localparam logic [STATUS_W-1:0] ST_BEGIN_SOH      = 4'd2;
   localparam logic [STATUS_W-1:0] ST_LEN_TAG        = 4'd3;
   localparam logic [STATUS_W-1:0] ST_LEN_NON_DIGIT  = 4'd4;
   localparam logic [STATUS_W-1:0] ST_LEN_TOO_LONG   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_LEN_EMPTY      = 4'd6;
   localparam logic [STATUS_W-1:0] ST_LEN_OVER_LIMIT = 4'd7;
   localparam logic [STATUS_W-1:0] ST_SUM_TAG        = 4'd8;
   localparam logic [STATUS_W-1:0] ST_SUM_NON_DIGIT  = 4'd9;
   localparam logic [STATUS_W-1:0] ST_SUM_SOH        = 4'd10;
   localparam logic [STATUS_W-1:0] ST_MISMATCH       = 4'd11;
   localparam logic [STATUS_W-1:0] ST_FINISH_CLEAN   = 4'd12;
   localparam logic [STATUS_W-1:0] ST_FINISH_PARTIAL = 4'd13;

   // one request
   typedef struct packed {
      logic              mode;
      logic [BYTE_W-1:0] data_byte;
   } item_type;

   // one result
   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [VERSION_W-1:0] fix_version;
      logic [LENGTH_W-1:0]  body_length;
      logic [COUNT_W-1:0]   message_length;
      logic [SUM_W-1:0]     computed_sum;
      logic [TRAILER_W-1:0] received_sum;
   } result_type;

   // step control from the framing core
   typedef struct packed {
      logic fire;
      logic load;
   } step_type;

endpackage

>>> rtl/fmfc_input_stage.sv
// ----------------------------------------------------------------------------
// fmfc_input_stage
// input register holding the next request for the framing core
// ----------------------------------------------------------------------------
module fmfc_input_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  fmfc_pkg::item_type req_item,
   input  fmfc_pkg::step_type step,
   output logic               item_valid,
   output fmfc_pkg::item_type item
);
   import fmfc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   // stall only while the held request is not consumed this cycle
   assign req_stall = valid_ff && !step.fire;
   assign accept    = req_valid && !req_stall;

   // occupancy of the input register
   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (step.fire) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/fmfc_frame_core.sv
// ----------------------------------------------------------------------------
// fmfc_frame_core
// framing state and per-byte checks, one request per cycle unless stalled
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmfc_frame_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  fmfc_pkg::item_type              item,
   input  logic                            out_free,
   input  logic                            csr_write_enable,
   input  logic [fmfc_pkg::LENGTH_W-1:0]   csr_write_data,
   output fmfc_pkg::step_type              step,
   output fmfc_pkg::result_type            result
);
   import fmfc_pkg::*;

   // framing phases
   localparam logic [3:0] PH_BEGIN      = 4'd0;
   localparam logic [3:0] PH_VERSION    = 4'd1;
   localparam logic [3:0] PH_BEGIN_SOH  = 4'd2;
   localparam logic [3:0] PH_LEN_TAG    = 4'd3;
   localparam logic [3:0] PH_LEN_DIGITS = 4'd4;
   localparam logic [3:0] PH_BODY       = 4'd5;
   localparam logic [3:0] PH_SUM_TAG    = 4'd6;
   localparam logic [3:0] PH_SUM_DIGITS = 4'd7;
   localparam logic [3:0] PH_SUM_SOH    = 4'd8;

   logic [3:0]           phase_ff,    phase_in,    phase_upd;
   logic [POS_W-1:0]     position_ff, position_in, position_upd;
   logic [VERSION_W-1:0] version_ff,  version_in,  version_upd;
   logic [DIGIT_W-1:0]   digits_ff,   digits_in,   digits_upd;
   logic [LENGTH_W-1:0]  declared_ff, declared_in, declared_upd;
   logic [LENGTH_W-1:0]  remain_ff,   remain_in,   remain_upd;
   logic [SUM_W-1:0]     sum_ff,      sum_in,      sum_upd;
   logic [TRAILER_W-1:0] trailer_ff,  trailer_in,  trailer_upd;
   logic [COUNT_W-1:0]   count_ff,    count_in,    count_upd;
   logic                 overflow_ff, overflow_in, overflow_upd;
   logic [LENGTH_W-1:0]  max_len_ff,  max_len_in;

   logic                 emit;
   logic [STATUS_W-1:0]  status;
   logic [BYTE_W-1:0]    data;
   logic [3:0]           digit;
   logic                 is_digit;
   logic [POS_W-1:0]     position_next;
   logic [LENGTH_W+3:0]  len_scaled;
   logic [TRAILER_W+3:0] trailer_scaled;
   logic [LENGTH_W-1:0]  remain_dec;
   logic                 fire;

   // byte decode
   assign data     = item.data_byte;
   assign digit    = data[3:0];
   assign is_digit = (data >= CHAR_0) && (data <= CHAR_9);

   // decimal accumulate: value times ten plus digit
   assign len_scaled = {1'b0, declared_ff, 3'b000} + {3'b000, declared_ff, 1'b0}
                     + {{LENGTH_W{1'b0}}, digit};
   assign trailer_scaled = {1'b0, trailer_ff, 3'b000} + {3'b000, trailer_ff, 1'b0}
                         + {{TRAILER_W{1'b0}}, digit};

   assign position_next = position_ff + 1'b1;
   assign remain_dec    = remain_ff - 1'b1;

   // per-byte framing step
   always_comb begin
      phase_upd    = phase_ff;
      position_upd = position_ff;
      version_upd  = version_ff;
      digits_upd   = digits_ff;
      declared_upd = declared_ff;
      remain_upd   = remain_ff;
      sum_upd      = sum_ff;
      trailer_upd  = trailer_ff;
      count_upd    = count_ff;
      overflow_upd = overflow_ff;
      emit         = 1'b0;
      status       = ST_OK;

      if (item.mode == MODE_FINISH) begin
         emit   = 1'b1;
         status = (count_ff == '0) ? ST_FINISH_CLEAN : ST_FINISH_PARTIAL;
      end else begin
         count_upd = count_ff + 1'b1;
         if (phase_ff < PH_SUM_TAG) begin
            sum_upd = sum_ff + data;
         end
         unique case (phase_ff)
            PH_VERSION: begin
               version_upd  = {version_ff[VERSION_W-BYTE_W-1:0], data};
               position_upd = position_next;
               if (position_next == POS_W'(VERSION_BYTES)) begin
                  position_upd = '0;
                  phase_upd    = PH_BEGIN_SOH;
               end
            end
            PH_BEGIN_SOH: begin
               if (data != CHAR_SOH) begin
                  emit   = 1'b1;
                  status = ST_BEGIN_SOH;
               end else begin
                  phase_upd = PH_LEN_TAG;
               end
            end
            PH_LEN_TAG: begin
               if (data != ((position_ff == '0) ? CHAR_9 : CHAR_EQ)) begin
                  emit   = 1'b1;
                  status = ST_LEN_TAG;
               end else if (position_next == POS_W'(LEN_TAG_LEN)) begin
                  position_upd = '0;
                  phase_upd    = PH_LEN_DIGITS;
               end else begin
                  position_upd = position_next;
               end
            end
            PH_LEN_DIGITS: begin
               priority if (is_digit) begin
                  if (digits_ff >= DIGIT_W'(MAX_LENGTH_DIGITS)) begin
                     emit   = 1'b1;
                     status = ST_LEN_TOO_LONG;
                  end else begin
                     digits_upd = digits_ff + 1'b1;
                     if (len_scaled[LENGTH_W+3:LENGTH_W] != '0) begin
                        overflow_upd = 1'b1;
                        declared_upd = '1;
                     end else begin
                        declared_upd = len_scaled[LENGTH_W-1:0];
                     end
                  end
               end else if (data != CHAR_SOH) begin
                  emit   = 1'b1;
                  status = ST_LEN_NON_DIGIT;
               end else if (digits_ff == '0) begin
                  emit   = 1'b1;
                  status = ST_LEN_EMPTY;
               end else if (overflow_ff || (declared_ff > max_len_ff)) begin
                  emit   = 1'b1;
                  status = ST_LEN_OVER_LIMIT;
               end else begin
                  remain_upd = declared_ff;
                  phase_upd  = (declared_ff != '0) ? PH_BODY : PH_SUM_TAG;
               end
            end
            PH_BODY: begin
               remain_upd = remain_dec;
               if (remain_dec == '0) begin
                  phase_upd = PH_SUM_TAG;
               end
            end
            PH_SUM_TAG: begin
               if (data != ((position_ff == '0) ? CHAR_1 :
                            (position_ff == POS_W'(1)) ? CHAR_0 : CHAR_EQ)) begin
                  emit   = 1'b1;
                  status = ST_SUM_TAG;
               end else if (position_next == POS_W'(SUM_TAG_LEN)) begin
                  position_upd = '0;
                  phase_upd    = PH_SUM_DIGITS;
               end else begin
                  position_upd = position_next;
               end
            end
            PH_SUM_DIGITS: begin
               if (!is_digit) begin
                  emit   = 1'b1;
                  status = ST_SUM_NON_DIGIT;
               end else begin
                  trailer_upd = trailer_scaled[TRAILER_W-1:0];
                  if (position_next == POS_W'(SUM_DIGITS)) begin
                     position_upd = '0;
                     phase_upd    = PH_SUM_SOH;
                  end else begin
                     position_upd = position_next;
                  end
               end
            end
            PH_SUM_SOH: begin
               emit = 1'b1;
               if (data != CHAR_SOH) begin
                  status = ST_SUM_SOH;
               end else if (trailer_ff == {{(TRAILER_W-SUM_W){1'b0}}, sum_ff}) begin
                  status = ST_OK;
               end else begin
                  status = ST_MISMATCH;
               end
            end
            default: begin
               // waiting for the begin tag
               if (data != ((position_ff == '0) ? CHAR_8 : CHAR_EQ)) begin
                  emit   = 1'b1;
                  status = ST_BEGIN_TAG;
               end else if (position_next == POS_W'(BEGIN_TAG_LEN)) begin
                  position_upd = '0;
                  phase_upd    = PH_VERSION;
               end else begin
                  position_upd = position_next;
               end
            end
         endcase
      end
   end

   // a request needs result space only when it produces a result
   assign fire      = item_valid && (!emit || out_free);
   assign step.fire = fire;
   assign step.load = fire && emit;

   // result fields as seen after this byte
   assign result.status         = status;
   assign result.fix_version    = version_upd;
   assign result.body_length    = declared_upd;
   assign result.message_length = count_upd;
   assign result.computed_sum   = sum_upd;
   assign result.received_sum   = trailer_upd;

   // state update, cleared after every result
   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      version_in  = version_ff;
      digits_in   = digits_ff;
      declared_in = declared_ff;
      remain_in   = remain_ff;
      sum_in      = sum_ff;
      trailer_in  = trailer_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (fire) begin
         if (emit) begin
            phase_in    = PH_BEGIN;
            position_in = '0;
            version_in  = '0;
            digits_in   = '0;
            declared_in = '0;
            remain_in   = '0;
            sum_in      = '0;
            trailer_in  = '0;
            count_in    = '0;
            overflow_in = 1'b0;
         end else begin
            phase_in    = phase_upd;
            position_in = position_upd;
            version_in  = version_upd;
            digits_in   = digits_upd;
            declared_in = declared_upd;
            remain_in   = remain_upd;
            sum_in      = sum_upd;
            trailer_in  = trailer_upd;
            count_in    = count_upd;
            overflow_in = overflow_upd;
         end
      end
   end

   // body length limit register
   assign max_len_in = csr_write_enable ? csr_write_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_BEGIN;
         position_ff <= '0;
         version_ff  <= '0;
         digits_ff   <= '0;
         declared_ff <= '0;
         remain_ff   <= '0;
         sum_ff      <= '0;
         trailer_ff  <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         max_len_ff  <= MAX_BODY_RESET;
      end else begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         version_ff  <= version_in;
         digits_ff   <= digits_in;
         declared_ff <= declared_in;
         remain_ff   <= remain_in;
         sum_ff      <= sum_in;
         trailer_ff  <= trailer_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         max_len_ff  <= max_len_in;
      end
   end

   // checks
   `FMFC_ASSERT(a_clear_after_result, clock, reset, step.load |=> (phase_ff == PH_BEGIN && count_ff == '0), "framing state not cleared after result")
   `FMFC_ASSERT(a_count_in_frame, clock, reset, (phase_ff != PH_BEGIN) |-> (count_ff != '0), "message in progress with zero byte count")
   `FMFC_NEVER(a_body_remaining, clock, reset, phase_ff == PH_BODY && remain_ff == '0, "body phase with nothing remaining")

endmodule

>>> rtl/fmfc_result_stage.sv
// ----------------------------------------------------------------------------
// fmfc_result_stage
// result register between the framing core and the response channel
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmfc_result_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  fmfc_pkg::step_type   step,
   input  fmfc_pkg::result_type result,
   input  logic                 rsp_stall,
   output logic                 out_free,
   output logic                 rsp_valid,
   output fmfc_pkg::result_type rsp_result
);
   import fmfc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // register can take a result when empty or being drained
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      if (step.load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step.load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   // checks
   `FMFC_ASSERT(a_load_into_free, clock, reset, step.load |-> (!valid_ff || !rsp_stall), "result loaded over a pending response")

endmodule

>>> rtl/fix_message_framer_checker.sv
// path: a request is held in the input register, its response in the result register
// throughput: one request per cycle unless responses stall, set by the framing update
//   (length times ten plus digit and the body count) between input and result registers
// a response stalled on the output does not block requests that give no response
// reset: synchronous, active high; clears framing state, sets max_body_length to 1048576
// ----------------------------------------------------------------------------
// fix_message_framer_checker
// frames a byte stream of fix messages and checks tags, length and checksum
// ----------------------------------------------------------------------------
module fix_message_framer_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_mode,
   input  logic [fmfc_pkg::BYTE_W-1:0]        req_data_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fmfc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fmfc_pkg::VERSION_W-1:0]     rsp_fix_version,
   output logic [fmfc_pkg::LENGTH_W-1:0]      rsp_body_length,
   output logic [fmfc_pkg::COUNT_W-1:0]       rsp_message_length,
   output logic [fmfc_pkg::SUM_W-1:0]         rsp_computed_sum,
   output logic [fmfc_pkg::TRAILER_W-1:0]     rsp_received_sum,
   input  logic                               csr_write_enable,
   input  logic [fmfc_pkg::LENGTH_W-1:0]      csr_write_data
);
   import fmfc_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   step_type   step;
   result_type core_result;
   result_type rsp_result;
   logic       out_free;

   assign req_item.mode      = req_mode;
   assign req_item.data_byte = req_data_byte;

   // input register
   fmfc_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .step       (step),
      .item_valid (item_valid),
      .item       (item)
   );

   // framing state and checks
   fmfc_frame_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item             (item),
      .out_free         (out_free),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step             (step),
      .result           (core_result)
   );

   // result register
   fmfc_result_stage u_result (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .result     (core_result),
      .rsp_stall  (rsp_stall),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   assign rsp_status         = rsp_result.status;
   assign rsp_fix_version    = rsp_result.fix_version;
   assign rsp_body_length    = rsp_result.body_length;
   assign rsp_message_length = rsp_result.message_length;
   assign rsp_computed_sum   = rsp_result.computed_sum;
   assign rsp_received_sum   = rsp_result.received_sum;

endmodule

>>> dv/fix_message_framer_checker_tb.sv
// ----------------------------------------------------------------------------
// fix_message_framer_checker_tb
// feeds fix byte streams and finish requests with random idling on both
// channels, predicts each frame verdict with a behavioral framer and compares
// every response field by field
// ----------------------------------------------------------------------------
module fix_message_framer_checker_tb;

   import fmfc_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_LIMIT  = 10;
   localparam int NO_FLAW       = -1;
   localparam int WHOLE_FRAME   = -1;
   localparam int TRUE_SUM      = -1;
   localparam logic [LENGTH_W-1:0] LENGTH_ALL_ONES = '1;

   // framer position within a message
   typedef enum logic [3:0] {
      FR_BEGIN,
      FR_VERSION,
      FR_BEGIN_SOH,
      FR_LEN_TAG,
      FR_LEN_DIGITS,
      FR_BODY,
      FR_SUM_TAG,
      FR_SUM_DIGITS,
      FR_SUM_SOH
   } frame_phase_type;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic                 req_mode         = MODE_DATA;
   logic [BYTE_W-1:0]    req_data_byte    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [VERSION_W-1:0] rsp_fix_version;
   logic [LENGTH_W-1:0]  rsp_body_length;
   logic [COUNT_W-1:0]   rsp_message_length;
   logic [SUM_W-1:0]     rsp_computed_sum;
   logic [TRAILER_W-1:0] rsp_received_sum;
   logic                 csr_write_enable = 1'b0;
   logic [LENGTH_W-1:0]  csr_write_data   = '0;

   // stimulus and scoreboard
   item_type   request_feed[$];
   result_type expected_verdicts[$];
   item_type   next_request;
   result_type seen_verdict;
   result_type want_verdict;
   logic       req_taken      = 1'b0;
   int         queued_count   = 0;
   int         issued_count   = 0;
   int         accepted_count = 0;
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   int         idle_pct       = 32;
   int         hold_requests  = 0;
   int         hold_served    = 0;
   int         hold_left      = 0;

   // behavioral framer state
   frame_phase_type      fr_phase     = FR_BEGIN;
   int                   fr_pos       = 0;
   logic [VERSION_W-1:0] fr_version   = '0;
   int                   fr_digits    = 0;
   logic [LENGTH_W-1:0]  fr_length    = '0;
   logic [LENGTH_W-1:0]  fr_remaining = '0;
   logic [SUM_W-1:0]     fr_sum       = '0;
   logic [TRAILER_W-1:0] fr_trailer   = '0;
   logic [COUNT_W-1:0]   fr_count     = '0;
   logic                 fr_overflow  = 1'b0;
   logic [LENGTH_W-1:0]  body_limit   = MAX_BODY_RESET;

   fix_message_framer_checker u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_fix_version    (rsp_fix_version),
      .rsp_body_length    (rsp_body_length),
      .rsp_message_length (rsp_message_length),
      .rsp_computed_sum   (rsp_computed_sum),
      .rsp_received_sum   (rsp_received_sum),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // close the current message with a verdict and clear the framing state
   task automatic post_verdict(input logic [STATUS_W-1:0] code);
      result_type verdict;
      verdict.status         = code;
      verdict.fix_version    = fr_version;
      verdict.body_length    = fr_length;
      verdict.message_length = fr_count;
      verdict.computed_sum   = fr_sum;
      verdict.received_sum   = fr_trailer;
      expected_verdicts.push_back(verdict);
      fr_phase     = FR_BEGIN;
      fr_pos       = 0;
      fr_version   = '0;
      fr_digits    = 0;
      fr_length    = '0;
      fr_remaining = '0;
      fr_sum       = '0;
      fr_trailer   = '0;
      fr_count     = '0;
      fr_overflow  = 1'b0;
   endtask

   // one accepted request through the framer
   task automatic advance_framer(input item_type req);
      logic [BYTE_W-1:0]   b;
      logic [LENGTH_W+3:0] grown;
      logic                is_digit;
      b        = req.data_byte;
      is_digit = (b >= CHAR_0) && (b <= CHAR_9);
      if (req.mode == MODE_FINISH) begin
         post_verdict((fr_count == 0) ? ST_FINISH_CLEAN : ST_FINISH_PARTIAL);
         return;
      end
      fr_count = fr_count + 1'b1;
      if (fr_phase < FR_SUM_TAG) fr_sum = fr_sum + b;
      case (fr_phase)
         FR_VERSION: begin
            fr_version = {fr_version[VERSION_W-BYTE_W-1:0], b};
            fr_pos++;
            if (fr_pos >= VERSION_BYTES) begin
               fr_pos   = 0;
               fr_phase = FR_BEGIN_SOH;
            end
         end
         FR_BEGIN_SOH: begin
            if (b != CHAR_SOH) post_verdict(ST_BEGIN_SOH);
            else fr_phase = FR_LEN_TAG;
         end
         FR_LEN_TAG: begin
            if (b != ((fr_pos == 0) ? CHAR_9 : CHAR_EQ)) begin
               post_verdict(ST_LEN_TAG);
            end else begin
               fr_pos++;
               if (fr_pos >= LEN_TAG_LEN) begin
                  fr_pos   = 0;
                  fr_phase = FR_LEN_DIGITS;
               end
            end
         end
         FR_LEN_DIGITS: begin
            if (is_digit) begin
               if (fr_digits >= MAX_LENGTH_DIGITS) begin
                  post_verdict(ST_LEN_TOO_LONG);
               end else begin
                  fr_digits++;
                  grown = {4'b0000, fr_length};
                  grown = grown * 10 + (b - CHAR_0);
                  // saturate once the value leaves 32 bits
                  if (grown[LENGTH_W+3:LENGTH_W] != 0) begin
                     fr_overflow = 1'b1;
                     fr_length   = LENGTH_ALL_ONES;
                  end else begin
                     fr_length = grown[LENGTH_W-1:0];
                  end
               end
            end else if (b != CHAR_SOH) begin
               post_verdict(ST_LEN_NON_DIGIT);
            end else if (fr_digits == 0) begin
               post_verdict(ST_LEN_EMPTY);
            end else if (fr_overflow || fr_length > body_limit) begin
               post_verdict(ST_LEN_OVER_LIMIT);
            end else begin
               fr_remaining = fr_length;
               fr_phase     = (fr_remaining != 0) ? FR_BODY : FR_SUM_TAG;
            end
         end
         FR_BODY: begin
            fr_remaining = fr_remaining - 1'b1;
            if (fr_remaining == 0) fr_phase = FR_SUM_TAG;
         end
         FR_SUM_TAG: begin
            if (b != ((fr_pos == 0) ? CHAR_1 : (fr_pos == 1) ? CHAR_0 : CHAR_EQ)) begin
               post_verdict(ST_SUM_TAG);
            end else begin
               fr_pos++;
               if (fr_pos >= SUM_TAG_LEN) begin
                  fr_pos   = 0;
                  fr_phase = FR_SUM_DIGITS;
               end
            end
         end
         FR_SUM_DIGITS: begin
            if (!is_digit) begin
               post_verdict(ST_SUM_NON_DIGIT);
            end else begin
               fr_trailer = TRAILER_W'(fr_trailer * 10 + (b - CHAR_0));
               fr_pos++;
               if (fr_pos >= SUM_DIGITS) begin
                  fr_pos   = 0;
                  fr_phase = FR_SUM_SOH;
               end
            end
         end
         FR_SUM_SOH: begin
            if (b != CHAR_SOH) post_verdict(ST_SUM_SOH);
            else post_verdict((fr_trailer == fr_sum) ? ST_OK : ST_MISMATCH);
         end
         default: begin
            if (b != ((fr_pos == 0) ? CHAR_8 : CHAR_EQ)) begin
               post_verdict(ST_BEGIN_TAG);
            end else begin
               fr_pos++;
               if (fr_pos >= BEGIN_TAG_LEN) begin
                  fr_pos   = 0;
                  fr_phase = FR_VERSION;
               end
            end
         end
      endcase
   endtask

   function automatic string show_verdict(input result_type r);
      return $sformatf({"status %0d version %014h body_length %0d message_length %0d",
                        " computed_sum %0d received_sum %0d"},
                       r.status, r.fix_version, r.body_length, r.message_length,
                       r.computed_sum, r.received_sum);
   endfunction

   task automatic log_failure(input string note);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", note);
   endtask

   // stimulus helpers
   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      item_type req;
      req.mode      = MODE_DATA;
      req.data_byte = b;
      request_feed.push_back(req);
      queued_count++;
   endtask

   task automatic queue_finish();
      item_type req;
      req.mode      = MODE_FINISH;
      req.data_byte = BYTE_W'($urandom_range(255));
      request_feed.push_back(req);
      queued_count++;
   endtask

   // bytes that matter to the framer show up more often than plain noise
   function automatic logic [BYTE_W-1:0] pick_tricky_byte();
      case ($urandom_range(7))
         0:       return CHAR_SOH;
         1:       return CHAR_8;
         2:       return CHAR_EQ;
         3:       return BYTE_W'(CHAR_0 + $urandom_range(9));
         4:       return CHAR_1;
         5:       return CHAR_9;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [VERSION_W-1:0] pick_version();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      if ($urandom_range(1) == 0) return raw[VERSION_W-1:0];
      return {"FIX.", 8'(CHAR_0 + $urandom_range(9)), ".", 8'(CHAR_0 + $urandom_range(9))};
   endfunction

   task automatic queue_noise(input int count);
      repeat (count) queue_byte(pick_tricky_byte());
   endtask

   // one message; sum_value below zero means the true checksum, flaw_at
   // overwrites one byte, keep_n below zero sends the whole frame
   task automatic queue_frame(input logic [VERSION_W-1:0] version, input string len_text,
                              input int body_n, input int sum_value, input int flaw_at,
                              input logic [BYTE_W-1:0] flaw_byte, input int keep_n);
      logic [BYTE_W-1:0] frame[$];
      logic [SUM_W-1:0]  sum;
      string             sum_text;
      int                send_n;
      frame.push_back(CHAR_8);
      frame.push_back(CHAR_EQ);
      for (int i = VERSION_BYTES - 1; i >= 0; i--) frame.push_back(version[i*BYTE_W +: BYTE_W]);
      frame.push_back(CHAR_SOH);
      frame.push_back(CHAR_9);
      frame.push_back(CHAR_EQ);
      for (int i = 0; i < len_text.len(); i++) frame.push_back(len_text[i]);
      frame.push_back(CHAR_SOH);
      repeat (body_n) frame.push_back(BYTE_W'($urandom_range(255)));
      sum = '0;
      foreach (frame[i]) sum = sum + frame[i];
      sum_text = $sformatf("%03d", (sum_value < 0) ? int'(sum) : sum_value);
      frame.push_back(CHAR_1);
      frame.push_back(CHAR_0);
      frame.push_back(CHAR_EQ);
      for (int i = 0; i < 3; i++) frame.push_back(sum_text[i]);
      frame.push_back(CHAR_SOH);
      if (flaw_at >= 0 && flaw_at < frame.size()) frame[flaw_at] = flaw_byte;
      send_n = (keep_n < 0 || keep_n > frame.size()) ? frame.size() : keep_n;
      for (int i = 0; i < send_n; i++) queue_byte(frame[i]);
   endtask

   // mostly well-formed messages, the rest damaged, cut short or noise
   task automatic queue_random_traffic(input int budget);
      int    start_count;
      int    pick;
      int    body_n;
      int    frame_len;
      string len_text;
      start_count = queued_count;
      while (queued_count - start_count < budget) begin
         pick     = $urandom_range(99);
         body_n   = ($urandom_range(19) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
         len_text = $sformatf("%0d", body_n);
         if ($urandom_range(7) == 0) len_text = {"0", len_text};
         frame_len = 20 + len_text.len() + body_n;
         if (pick < 55) begin
            queue_frame(pick_version(), len_text, body_n, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
         end else if (pick < 65) begin
            queue_frame(pick_version(), len_text, body_n, $urandom_range(999), NO_FLAW, '0,
                        WHOLE_FRAME);
         end else if (pick < 80) begin
            queue_frame(pick_version(), len_text, body_n, TRUE_SUM,
                        $urandom_range(frame_len - 1), pick_tricky_byte(), WHOLE_FRAME);
         end else if (pick < 88) begin
            queue_frame(pick_version(), len_text, body_n, TRUE_SUM, NO_FLAW, '0,
                        $urandom_range(1, frame_len - 1));
            queue_finish();
         end else if (pick < 93) begin
            // random length text; a finish ends any body it opens
            len_text = "";
            repeat ($urandom_range(1, 11)) len_text = {len_text, $sformatf("%0d", $urandom_range(9))};
            queue_frame(pick_version(), len_text, body_n, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
            queue_finish();
         end else if (pick < 97) begin
            queue_noise($urandom_range(1, 6));
         end else begin
            queue_finish();
         end
      end
   endtask

   // pause the sender until every verdict is back and the block has settled
   task automatic wait_for_verdicts();
      while (request_feed.size() != 0 || accepted_count != issued_count
             || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_body_limit(input logic [LENGTH_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      body_limit = value;
      @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (request_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_request = request_feed.pop_front();
            req_mode      <= next_request.mode;
            req_data_byte <= next_request.data_byte;
            req_valid     <= 1'b1;
            issued_count++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response receiver with random stalls and long hold-offs on request
   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   // monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         advance_framer(item_type'{mode: req_mode, data_byte: req_data_byte});
         accepted_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_verdict = {rsp_status, rsp_fix_version, rsp_body_length, rsp_message_length,
                         rsp_computed_sum, rsp_received_sum};
         if (expected_verdicts.size() == 0) begin
            log_failure({"response with nothing expected: ", show_verdict(seen_verdict)});
         end else begin
            want_verdict = expected_verdicts.pop_front();
            if (seen_verdict.status !== want_verdict.status
                || seen_verdict.fix_version !== want_verdict.fix_version
                || seen_verdict.body_length !== want_verdict.body_length
                || seen_verdict.message_length !== want_verdict.message_length
                || seen_verdict.computed_sum !== want_verdict.computed_sum
                || seen_verdict.received_sum !== want_verdict.received_sum)
               log_failure({"response mismatch\n  expected ", show_verdict(want_verdict),
                            "\n  actual   ", show_verdict(seen_verdict)});
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // stray bytes and a finish on an empty stream
      queue_finish();
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CHAR_8);
      queue_byte(8'h3E);
      // clean frames, empty body and short body, version extremes
      queue_frame('0, "0", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame('1, "3", 3, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      // header errors: begin soh, length tag at both positions
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 9, 8'h02, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 10, CHAR_8, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 11, CHAR_9, WHOLE_FRAME);
      // length errors: non-digits at the digit boundaries, too many, empty, too big
      queue_frame(pick_version(), "1/", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "2:", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "00000000001", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "1048577", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "4294967296", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "9999999999", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      // trailer errors on a zero-length frame: tag bytes, digits, closing soh
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 14, CHAR_0, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 15, CHAR_1, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 16, CHAR_SOH, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 17, 8'h2F, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 19, 8'h3A, WHOLE_FRAME);
      queue_frame(pick_version(), "0", 0, TRUE_SUM, 20, CHAR_0, WHOLE_FRAME);
      // checksum mismatch, including values above 255
      queue_frame(pick_version(), "2", 2, 999, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "2", 2, 256, NO_FLAW, '0, WHOLE_FRAME);
      // partial message closed by finish
      queue_frame(pick_version(), "5", 5, TRUE_SUM, NO_FLAW, '0, 12);
      queue_finish();
      queue_random_traffic(50);
      wait_for_verdicts();

      // receiver holds off while requests that mostly make a response pile up
      hold_requests++;
      repeat (40) begin
         if ($urandom_range(1) == 0) queue_finish();
         else queue_noise(1);
      end
      wait_for_verdicts();

      // no body allowed at all, and no idling on either side
      write_body_limit('0);
      idle_pct = 0;
      queue_frame(pick_version(), "0", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_frame(pick_version(), "1", 1, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_random_traffic(40);
      wait_for_verdicts();
      idle_pct = 32;

      // small limit
      write_body_limit($urandom_range(1, 8));
      queue_random_traffic(40);
      wait_for_verdicts();

      // widest limit: largest length accepted, one past it flagged
      write_body_limit(LENGTH_ALL_ONES);
      queue_frame(pick_version(), "4294967295", 3, TRUE_SUM, NO_FLAW, '0, 26);
      queue_finish();
      queue_frame(pick_version(), "4294967296", 0, TRUE_SUM, NO_FLAW, '0, WHOLE_FRAME);
      queue_random_traffic(40);
      wait_for_verdicts();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
